### sv/prc_pkg.sv
// prc_pkg: item types, register indexes and sizing constants shared by the
// clamped PID rate controller and its serial arithmetic units.
// No dependencies.
`default_nettype none

package prc_pkg;

  // Input item: pitch sample and time since the previous sample
  typedef struct packed {
    logic signed [15:0] pitch_sample;
    logic        [15:0] elapsed_us;
  } in_item_t;

  // Result item: clamped rate command and clamp flag
  typedef struct packed {
    logic signed [15:0] rate_command;
    logic               was_clamped;
  } out_item_t;

  // Configuration port
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] RegGainP     = 8'd0;
  localparam logic [CfgIdxW-1:0] RegGainI     = 8'd1;
  localparam logic [CfgIdxW-1:0] RegGainD     = 8'd2;
  localparam logic [CfgIdxW-1:0] RegRateLimit = 8'd3;

  localparam logic [23:0] GainPReset     = 24'd1064960;
  localparam logic [23:0] GainIReset     = 24'd32768;
  localparam logic [23:0] GainDReset     = 24'd410;
  localparam logic [14:0] RateLimitReset = 15'd1280;

  // Microseconds per second, used both as multiplier and as divisor
  localparam logic [23:0] UsPerS = 24'd1000000;

  // Serial multiplier: 24-bit multiplier, 48-bit multiplicand, 2 bits a cycle
  localparam int MulAW     = 24;
  localparam int MulBW     = 48;
  localparam int ProdW     = MulAW + MulBW;
  localparam int MulDigit  = 2;
  localparam int MulSteps  = MulAW / MulDigit;
  localparam int MulCntW   = $clog2(MulSteps);

  // Serial divider: 72-bit dividend, 20-bit divisor, 2 quotient bits a cycle
  localparam int DvdW      = 72;
  localparam int DsrW      = 20;
  localparam int DivDigit  = 2;
  localparam int DivDigits = DvdW / DivDigit;
  localparam int DivCntW   = $clog2(DivDigits + 1);
  // Derivative quotient is 36 bits wide, so its division runs half length
  localparam int DerivW      = 36;
  localparam int DerivDigits = DerivW / DivDigit;

  // Correction accumulator width (signed)
  localparam int CorrW = 63;

  // Divider launch control
  typedef struct packed {
    logic               start;
    logic [DivCntW-1:0] digits;
  } div_ctrl_t;

endpackage

`default_nettype wire

### sv/pid_rate_controller_clamped.sv
// pid_rate_controller_clamped: top level of the clamped PID rate controller.
// Depends on prc_pkg, prc_smul and prc_sdiv.
//
// Each accepted item (pitch in Q3.12 rad, elapsed time in us, zero taken as
// 1 us) yields one result: the command -(Kp*e + Ki*integral/1e6 + Kd*de*1e6/dt)
// clamped to +-rate_limit in Q8.8 rad/s, rounded to nearest, with a clamp
// flag. Gains are unsigned Q12.12 and may be written through the cfg port
// while the block is idle; cfg_ready is always high. Items are handled one
// at a time: in_stall is low only while the block is idle, and the block
// returns to idle once the result is loaded, which waits until the
// previous result has been taken. Two 2-bit-per-cycle multipliers and one
// shared 2-bit-per-cycle divider do the arithmetic; the division of the
// integral product by 10^6, the longest step, runs after the division for
// the derivative. The result waits in an output register, so the next item
// can be accepted before it is taken.
`default_nettype none

module pid_rate_controller_clamped import prc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input items
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_item,
  // result items
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_item,
  // configuration writes
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_WAIT1 = 4'd2;
  localparam logic [3:0] S_INT   = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_WAIT2 = 4'd5;
  localparam logic [3:0] S_MUL3  = 4'd6;
  localparam logic [3:0] S_WAIT3 = 4'd7;
  localparam logic [3:0] S_SUM1  = 4'd8;
  localparam logic [3:0] S_SUM2  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  localparam logic [47:0] IntMax = {1'b0, {47{1'b1}}};
  localparam logic [47:0] IntMin = {1'b1, {47{1'b0}}};

  logic [3:0]       state_r, state_nxt;

  // Configuration registers
  logic [23:0]      gain_p_r, gain_i_r, gain_d_r;
  logic [14:0]      rate_limit_r;

  // Controller state
  logic [47:0]      int_r, int_nxt;
  logic [16:0]      prior_r, prior_nxt;

  // Per-item working registers
  logic             e_neg_r, e_neg_nxt;
  logic [15:0]      e_mag_r, e_mag_nxt;
  logic             d_neg_r, d_neg_nxt;
  logic [15:0]      d_mag_r, d_mag_nxt;
  logic [15:0]      dt_r, dt_nxt;
  logic [CorrW-1:0] cacc_r, cacc_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  // Arithmetic unit connections
  logic             a_start, b_start;
  logic [MulAW-1:0] a_mplier, b_mplier;
  logic [MulBW-1:0] a_mcand, b_mcand;
  logic             a_busy, b_busy, div_busy;
  logic [ProdW-1:0] a_prod, b_prod;
  div_ctrl_t        div_ctrl;
  logic [DvdW-1:0]  div_dvd, div_quot;
  logic [DsrW-1:0]  div_dsr;

  logic             in_take, out_take;
  logic [47:0]      int_mag;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign int_mag  = int_r[47] ? (48'd0 - int_r) : int_r;

  prc_smul u_mul_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (a_start),
    .mplier (a_mplier),
    .mcand  (a_mcand),
    .busy   (a_busy),
    .prod   (a_prod)
  );

  prc_smul u_mul_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (b_start),
    .mplier (b_mplier),
    .mcand  (b_mcand),
    .busy   (b_busy),
    .prod   (b_prod)
  );

  prc_sdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  // Unit operand selection by sequencer state
  always_comb begin
    a_start         = 1'b0;
    a_mplier        = {8'd0, dt_r};
    a_mcand         = {32'd0, e_mag_r};
    b_start         = 1'b0;
    b_mplier        = UsPerS;
    b_mcand         = {32'd0, d_mag_r};
    div_ctrl.start  = 1'b0;
    div_ctrl.digits = DivCntW'(DerivDigits);
    div_dvd         = {b_prod[DerivW-1:0], {(DvdW-DerivW){1'b0}}};
    div_dsr         = {4'd0, dt_r};
    unique case (state_r)
      S_MUL1: begin
        // e*dt on A, |de|*1e6 on B
        a_start = 1'b1;
        b_start = 1'b1;
      end
      S_MUL2: begin
        // Ki*|integral| on A, Kp*|e| on B, derivative division
        a_start        = 1'b1;
        a_mplier       = gain_i_r;
        a_mcand        = int_mag;
        b_start        = 1'b1;
        b_mplier       = gain_p_r;
        b_mcand        = {32'd0, e_mag_r};
        div_ctrl.start = 1'b1;
      end
      S_MUL3: begin
        // Kd*|deriv| on B, integral product divided by 1e6
        b_start         = 1'b1;
        b_mplier        = gain_d_r;
        b_mcand         = {12'd0, div_quot[DerivW-1:0]};
        div_ctrl.start  = 1'b1;
        div_ctrl.digits = DivCntW'(DivDigits);
        div_dvd         = a_prod;
        div_dsr         = UsPerS[DsrW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Sequencer and datapath next values
  always_comb begin
    logic signed [16:0] e17;
    logic signed [17:0] diff;
    logic [16:0]        e_abs;
    logic [17:0]        d_abs;
    logic [48:0]        edt;
    logic [48:0]        isum;
    logic [CorrW-1:0]   lim;
    logic               over, under;
    logic [31:0]        rnd;
    logic [15:0]        lim16;

    state_nxt     = state_r;
    int_nxt       = int_r;
    prior_nxt     = prior_r;
    e_neg_nxt     = e_neg_r;
    e_mag_nxt     = e_mag_r;
    d_neg_nxt     = d_neg_r;
    d_mag_nxt     = d_mag_r;
    dt_nxt        = dt_r;
    cacc_nxt      = cacc_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_take;

    // Item intake: error, change in error, magnitudes and signs
    e17   = 17'sd0 - {in_item.pitch_sample[15], in_item.pitch_sample};
    diff  = {e17[16], e17} - {prior_r[16], prior_r};
    e_abs = e17[16] ? (17'd0 - e17) : e17;
    d_abs = diff[17] ? (18'd0 - diff) : diff;

    // Integral update with saturation at 48 bits
    edt  = {16'd0, a_prod[32:0]};
    edt  = e_neg_r ? (49'd0 - edt) : edt;
    isum = {int_r[47], int_r} + edt;

    // Clamp and rounding of the correction
    lim   = {32'd0, rate_limit_r, 16'd0};
    over  = $signed(cacc_r) > $signed(lim);
    under = $signed(cacc_r) < -$signed(lim);
    rnd   = cacc_r[31:0] + 32'h0000_8000;
    lim16 = {1'b0, rate_limit_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          e_neg_nxt = e17[16];
          e_mag_nxt = e_abs[15:0];
          d_neg_nxt = diff[17];
          d_mag_nxt = d_abs[15:0];
          dt_nxt    = (in_item.elapsed_us == 16'd0) ? 16'd1 : in_item.elapsed_us;
          prior_nxt = e17;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: state_nxt = S_WAIT1;
      S_WAIT1: begin
        if (!a_busy && !b_busy) begin
          state_nxt = S_INT;
        end
      end
      S_INT: begin
        if (isum[48] != isum[47]) begin
          int_nxt = isum[48] ? IntMin : IntMax;
        end else begin
          int_nxt = isum[47:0];
        end
        state_nxt = S_MUL2;
      end
      S_MUL2: state_nxt = S_WAIT2;
      S_WAIT2: begin
        if (!a_busy && !b_busy && !div_busy) begin
          state_nxt = S_MUL3;
        end
      end
      S_MUL3: begin
        // c starts as -sign(e)*P
        cacc_nxt  = e_neg_r ? {23'd0, b_prod[39:0]}
                            : (CorrW'(0) - {23'd0, b_prod[39:0]});
        state_nxt = S_WAIT3;
      end
      S_WAIT3: begin
        if (!b_busy && !div_busy) begin
          state_nxt = S_SUM1;
        end
      end
      S_SUM1: begin
        cacc_nxt  = d_neg_r ? (cacc_r + {1'b0, b_prod[61:0]})
                            : (cacc_r - {1'b0, b_prod[61:0]});
        state_nxt = S_SUM2;
      end
      S_SUM2: begin
        cacc_nxt  = int_r[47] ? (cacc_r + {11'd0, div_quot[51:0]})
                              : (cacc_r - {11'd0, div_quot[51:0]});
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.was_clamped  = over || under;
          if (over) begin
            out_nxt.rate_command = lim16;
          end else if (under) begin
            out_nxt.rate_command = 16'd0 - lim16;
          end else begin
            out_nxt.rate_command = rnd[31:16];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      int_r        <= '0;
      prior_r      <= '0;
      gain_p_r     <= GainPReset;
      gain_i_r     <= GainIReset;
      gain_d_r     <= GainDReset;
      rate_limit_r <= RateLimitReset;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      int_r       <= int_nxt;
      prior_r     <= prior_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          RegGainP:     gain_p_r     <= cfg_data;
          RegGainI:     gain_i_r     <= cfg_data;
          RegGainD:     gain_d_r     <= cfg_data;
          RegRateLimit: rate_limit_r <= cfg_data[14:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    e_neg_r <= e_neg_nxt;
    e_mag_r <= e_mag_nxt;
    d_neg_r <= d_neg_nxt;
    d_mag_r <= d_mag_nxt;
    dt_r    <= dt_nxt;
    cacc_r  <= cacc_nxt;
    out_r   <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign cfg_ready = 1'b1;

  // A unit is never relaunched while it is still working
  a_mul_a_free: assert property (@(posedge clk) disable iff (!rst_n)
    a_start |-> !a_busy)
    else $error("multiplier A launched while busy");

  a_mul_b_free: assert property (@(posedge clk) disable iff (!rst_n)
    b_start |-> !b_busy)
    else $error("multiplier B launched while busy");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctrl.start |-> !div_busy)
    else $error("divider launched while busy");

  // Summation only starts once the last products are complete
  a_sum_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM1) |-> (!a_busy && !b_busy && !div_busy))
    else $error("summation began with a unit still busy");

  // An accepted item always launches both multipliers next cycle
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (a_start && b_start))
    else $error("accepted item did not launch the multipliers");

endmodule

`default_nettype wire

### sv/prc_smul.sv
// prc_smul: unsigned shift-and-add multiplier, two multiplier bits a cycle.
// Depends on prc_pkg for widths and step count.
`default_nettype none

module prc_smul import prc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [MulAW-1:0] mplier,
  input  wire logic [MulBW-1:0] mcand,
  output logic                  busy,
  output logic [ProdW-1:0]      prod
);

  logic [ProdW-1:0]   p_r, p_nxt;
  logic [MulBW-1:0]   mc_r;
  logic [MulCntW-1:0] cnt_r;
  logic               busy_r;

  // Two right-shifting add steps; the upper 48 bits accumulate, the lower 24
  // bits hold the multiplier bits still to be consumed
  always_comb begin
    logic [MulBW:0]   sum;
    logic [ProdW:0]   wide;
    p_nxt = p_r;
    for (int k = 0; k < MulDigit; k++) begin
      sum   = {1'b0, p_nxt[ProdW-1:MulAW]} + (p_nxt[0] ? {1'b0, mc_r} : '0);
      wide  = {sum, p_nxt[MulAW-1:0]};
      p_nxt = wide[ProdW:1];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= MulCntW'(MulSteps - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      p_r  <= {{MulBW{1'b0}}, mplier};
      mc_r <= mcand;
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign busy = busy_r;
  assign prod = p_r;

endmodule

`default_nettype wire

### sv/prc_sdiv.sv
// prc_sdiv: unsigned restoring divider, two quotient bits a cycle, with a
// selectable digit count. The dividend is left-aligned by the caller.
// Depends on prc_pkg for widths and div_ctrl_t.
`default_nettype none

module prc_sdiv import prc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire div_ctrl_t       ctrl,
  input  wire logic [DvdW-1:0] dividend,
  input  wire logic [DsrW-1:0] divisor,
  output logic                 busy,
  output logic [DvdW-1:0]      quot
);

  logic [DsrW-1:0]    rem_r, rem_nxt;
  logic [DvdW-1:0]    dvd_r, dvd_nxt;
  logic [DvdW-1:0]    quo_r, quo_nxt;
  logic [DsrW-1:0]    dsr_r;
  logic [DivCntW-1:0] cnt_r;
  logic               busy_r;

  // Two compare-and-subtract steps; the remainder stays below the divisor
  always_comb begin
    logic [DsrW:0] t;
    logic          ge;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    quo_nxt = quo_r;
    for (int k = 0; k < DivDigit; k++) begin
      t       = {rem_nxt, dvd_nxt[DvdW-1]};
      ge      = (t >= {1'b0, dsr_r});
      rem_nxt = ge ? DsrW'(t - {1'b0, dsr_r}) : t[DsrW-1:0];
      dvd_nxt = {dvd_nxt[DvdW-2:0], 1'b0};
      quo_nxt = {quo_nxt[DvdW-2:0], ge};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctrl.start) begin
      busy_r <= 1'b1;
      cnt_r  <= ctrl.digits - 1'b1;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      quo_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;

endmodule

`default_nettype wire
